@@ rtl/core/bcb_pkg.sv @@
// ----------------------------------------------------------------------------
// bcb_pkg
// Shared widths, register indexes, reset values and the box type for the
// blob centroid and bounding box block.
// ----------------------------------------------------------------------------
package bcb_pkg;

  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 10;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 10;
  localparam int SUM_W      = 30;
  localparam int CNT_W      = 21;
  localparam int SLOT_W     = 6;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_STEP_W = $clog2(SUM_W);

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(40);
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(45);
  localparam logic [COORD_W-1:0]  RST_XMIN   = COORD_W'(36);
  localparam logic [COORD_W-1:0]  RST_XMAX   = COORD_W'(44);
  localparam logic [COORD_W-1:0]  RST_YMIN   = COORD_W'(20);
  localparam logic [COORD_W-1:0]  RST_YMAX   = COORD_W'(24);
  localparam logic [SLOT_W-1:0]   RST_HIST   = SLOT_W'(10);
  localparam logic [BYTE_W-1:0]   RST_THRESH = BYTE_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_XMIN   = 3'd2,
    REG_XMAX   = 3'd3,
    REG_YMIN   = 3'd4,
    REG_YMAX   = 3'd5,
    REG_HIST   = 3'd6,
    REG_THRESH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] xmin;
    logic [COORD_W-1:0] xmax;
    logic [COORD_W-1:0] ymin;
    logic [COORD_W-1:0] ymax;
  } box_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } accum_t;

endpackage

@@ rtl/core/bcb_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// bcb_pixel_unit
// Shared per-pixel unit: threshold compares, red accumulation and green box
// widening for one pixel at a time.
// ----------------------------------------------------------------------------
module bcb_pixel_unit (
  input  logic [bcb_pkg::BYTE_W-1:0]  red,
  input  logic [bcb_pkg::BYTE_W-1:0]  green,
  input  logic [bcb_pkg::BYTE_W-1:0]  threshold,
  input  logic [bcb_pkg::COORD_W-1:0] x,
  input  logic [bcb_pkg::COORD_W-1:0] y,
  input  bcb_pkg::accum_t             acc_in,
  input  bcb_pkg::box_t               box_in,
  output bcb_pkg::accum_t             acc_out,
  output bcb_pkg::box_t               box_out
);
  import bcb_pkg::*;

  logic hit_red;
  logic hit_green;

  assign hit_red   = red > threshold;
  assign hit_green = green > threshold;

  always_comb begin
    acc_out = acc_in;
    box_out = box_in;
    if (hit_red) begin
      acc_out.sum_x = acc_in.sum_x + SUM_W'(x);
      acc_out.sum_y = acc_in.sum_y + SUM_W'(y);
      acc_out.count = acc_in.count + CNT_W'(1);
    end
    if (hit_green) begin
      if (x < box_in.xmin) box_out.xmin = x;
      if (x > box_in.xmax) box_out.xmax = x;
      if (y < box_in.ymin) box_out.ymin = y;
      if (y > box_in.ymax) box_out.ymax = y;
    end
  end

endmodule

@@ rtl/core/bcb_divider.sv @@
// ----------------------------------------------------------------------------
// bcb_divider
// Restoring divider, one quotient bit per cycle, shared by the x and y
// centroid divisions.
// ----------------------------------------------------------------------------
module bcb_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bcb_pkg::SUM_W-1:0]  dividend,
  input  logic [bcb_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [bcb_pkg::SUM_W-1:0]  quotient
);
  import bcb_pkg::*;

  logic                  busy_r,  busy_nxt;
  logic                  done_r,  done_nxt;
  logic [DIV_STEP_W-1:0] step_r,  step_nxt;
  logic [CNT_W-1:0]      rem_r,   rem_nxt;
  logic [CNT_W-1:0]      dvs_r,   dvs_nxt;
  logic [SUM_W-1:0]      quo_r,   quo_nxt;
  logic [CNT_W:0]        shifted;
  logic [CNT_W:0]        diff;
  logic                  fits;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r + DIV_STEP_W'(1);
      if (step_r == DIV_STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/blob_centroid_and_bounding_box.sv @@
// ----------------------------------------------------------------------------
// blob_centroid_and_bounding_box
// Red-mask centroid and green-mask bounding box over a streamed raster.
// ----------------------------------------------------------------------------
// Each input item is one word of two adjacent pixels, in row order; the block
// counts columns and rows itself and emits one result on the last word of a
// frame. The shared pixel unit handles the left pixel of a word in the accept
// cycle and the right pixel in the next one, and in_tready is low in between.
// The last word of a frame with red pixels is further held by the 30-step
// restoring divider, run once for x and once for y; with no red pixel the
// result goes straight to the output stage. Either way the last word also
// waits while the output register still holds an unaccepted result. A finished
// result sits in the output register while the next frame streams in.
// ----------------------------------------------------------------------------
module blob_centroid_and_bounding_box #(
  parameter int MAX_WIDTH_WORDS = 512,
  parameter int MAX_HEIGHT      = 1024,
  parameter int MAX_HISTORY     = 60
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // left_red, left_green, right_red, right_green
  input  logic [31:0]                   in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // centroid_x, centroid_y, green_xmin, green_xmax, green_ymin, green_ymax,
  // history_slot, red_pixel_count, zero pad
  output logic [87:0]                   out_tdata,
  // blob_found
  output logic                          out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcb_pkg::*;

  localparam int WBW_RAW = $clog2(MAX_WIDTH_WORDS + 1);
  localparam int HBW_RAW = $clog2(MAX_HEIGHT + 1);
  localparam int LBW_RAW = $clog2(MAX_HISTORY + 1);
  localparam int WBW = (WBW_RAW > WIDTH_W) ? WBW_RAW : WIDTH_W;
  localparam int HBW = (HBW_RAW > HEIGHT_W) ? HBW_RAW : HEIGHT_W;
  localparam int LBW = (LBW_RAW > SLOT_W + 1) ? LBW_RAW : SLOT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX1,
    ST_DIVX_GO,
    ST_DIVX,
    ST_DIVY_GO,
    ST_DIVY,
    ST_PUSH
  } state_t;

  state_t              state_r,  state_nxt;
  logic [WIDTH_W-1:0]  width_r,  width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  box_t                start_r,  start_nxt;
  logic [SLOT_W-1:0]   hist_r,   hist_nxt;
  logic [BYTE_W-1:0]   thresh_r, thresh_nxt;
  logic [COL_W-1:0]    col_r,    col_nxt;
  logic [ROW_W-1:0]    row_r,    row_nxt;
  accum_t              acc_r,    acc_nxt;
  box_t                box_r,    box_nxt;
  logic [SLOT_W-1:0]   slot_r,   slot_nxt;
  logic [15:0]         right_r,  right_nxt;
  logic [COORD_W-1:0]  cx_r,     cx_nxt;
  logic [COORD_W-1:0]  cy_r,     cy_nxt;
  logic [87:0]         odata_r,  odata_nxt;
  logic                ouser_r,  ouser_nxt;
  logic                ovalid_r, ovalid_nxt;

  logic                accept;
  logic                pix_sel;
  logic [BYTE_W-1:0]   pu_red;
  logic [BYTE_W-1:0]   pu_green;
  logic [COORD_W-1:0]  pu_x;
  box_t                pu_box_in;
  accum_t              pu_acc;
  box_t                pu_box;

  logic [WBW-1:0]      w_bnd;
  logic [HBW-1:0]      h_bnd;
  logic [LBW-1:0]      l_bnd;
  logic                row_end;
  logic                frame_end;
  logic                found;
  logic                out_free;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;

  // register bounds: zero acts as one, large values clamp
  always_comb begin
    if (width_r == '0) w_bnd = WBW'(1);
    else if (WBW'(width_r) > WBW'(MAX_WIDTH_WORDS)) w_bnd = WBW'(MAX_WIDTH_WORDS);
    else w_bnd = WBW'(width_r);
    if (height_r == '0) h_bnd = HBW'(1);
    else if (HBW'(height_r) > HBW'(MAX_HEIGHT)) h_bnd = HBW'(MAX_HEIGHT);
    else h_bnd = HBW'(height_r);
    if (hist_r == '0) l_bnd = LBW'(1);
    else if (LBW'(hist_r) > LBW'(MAX_HISTORY)) l_bnd = LBW'(MAX_HISTORY);
    else l_bnd = LBW'(hist_r);
  end

  assign row_end   = ((WBW + 1)'(col_r) + (WBW + 1)'(1)) >= (WBW + 1)'(w_bnd);
  assign frame_end = row_end &&
                     (((HBW + 1)'(row_r) + (HBW + 1)'(1)) >= (HBW + 1)'(h_bnd));
  assign found     = acc_r.count != '0;
  assign out_free  = !ovalid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // left pixel in the accept cycle, right pixel from the held half word
  assign pix_sel   = (state_r == ST_PIX1);
  assign pu_red    = pix_sel ? right_r[7:0]  : in_tdata[7:0];
  assign pu_green  = pix_sel ? right_r[15:8] : in_tdata[15:8];
  assign pu_x      = {col_r, pix_sel};
  assign pu_box_in = (!pix_sel && col_r == '0 && row_r == '0) ? start_r : box_r;

  bcb_pixel_unit u_pixel (
    .red       (pu_red),
    .green     (pu_green),
    .threshold (thresh_r),
    .x         (pu_x),
    .y         (row_r),
    .acc_in    (acc_r),
    .box_in    (pu_box_in),
    .acc_out   (pu_acc),
    .box_out   (pu_box)
  );

  assign div_start    = (state_r == ST_DIVX_GO) || (state_r == ST_DIVY_GO);
  assign div_dividend = (state_r == ST_DIVY_GO) ? acc_r.sum_y : acc_r.sum_x;

  bcb_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (acc_r.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    start_nxt  = start_r;
    hist_nxt   = hist_r;
    thresh_nxt = thresh_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    acc_nxt    = acc_r;
    box_nxt    = box_r;
    slot_nxt   = slot_r;
    right_nxt  = right_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    ovalid_nxt = (ovalid_r && out_tready) ? 1'b0 : ovalid_r;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_nxt     = cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_nxt    = cfg_data[HEIGHT_W-1:0];
        REG_XMIN:   start_nxt.xmin = cfg_data[COORD_W-1:0];
        REG_XMAX:   start_nxt.xmax = cfg_data[COORD_W-1:0];
        REG_YMIN:   start_nxt.ymin = cfg_data[COORD_W-1:0];
        REG_YMAX:   start_nxt.ymax = cfg_data[COORD_W-1:0];
        REG_HIST:   hist_nxt      = cfg_data[SLOT_W-1:0];
        REG_THRESH: thresh_nxt    = cfg_data[BYTE_W-1:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = pu_acc;
          box_nxt   = pu_box;
          right_nxt = in_tdata[31:16];
          state_nxt = ST_PIX1;
        end
      end
      ST_PIX1: begin
        acc_nxt = pu_acc;
        box_nxt = pu_box;
        if (!row_end) begin
          col_nxt   = col_r + COL_W'(1);
          state_nxt = ST_IDLE;
        end else if (!frame_end) begin
          col_nxt   = '0;
          row_nxt   = row_r + ROW_W'(1);
          state_nxt = ST_IDLE;
        end else begin
          col_nxt   = '0;
          row_nxt   = '0;
          cx_nxt    = '0;
          cy_nxt    = '0;
          state_nxt = (pu_acc.count != '0) ? ST_DIVX_GO : ST_PUSH;
        end
      end
      ST_DIVX_GO: state_nxt = ST_DIVX;
      ST_DIVX: begin
        if (div_done) begin
          cx_nxt    = div_quo[COORD_W-1:0];
          state_nxt = ST_DIVY_GO;
        end
      end
      ST_DIVY_GO: state_nxt = ST_DIVY;
      ST_DIVY: begin
        if (div_done) begin
          cy_nxt    = div_quo[COORD_W-1:0];
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          ouser_nxt  = found;
          ovalid_nxt = 1'b1;
          odata_nxt  = {1'b0, acc_r.count, (found ? slot_r : SLOT_W'(0)),
                        box_r.ymax, box_r.ymin, box_r.xmax, box_r.xmin,
                        cy_r, cx_r};
          if (found) begin
            if ((LBW'(slot_r) + LBW'(1)) >= l_bnd) slot_nxt = '0;
            else slot_nxt = slot_r + SLOT_W'(1);
          end
          acc_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      start_r.xmin <= RST_XMIN;
      start_r.xmax <= RST_XMAX;
      start_r.ymin <= RST_YMIN;
      start_r.ymax <= RST_YMAX;
      hist_r       <= RST_HIST;
      thresh_r     <= RST_THRESH;
      col_r        <= '0;
      row_r        <= '0;
      acc_r        <= '0;
      box_r.xmin   <= RST_XMIN;
      box_r.xmax   <= RST_XMAX;
      box_r.ymin   <= RST_YMIN;
      box_r.ymax   <= RST_YMAX;
      slot_r       <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      start_r  <= start_nxt;
      hist_r   <= hist_nxt;
      thresh_r <= thresh_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      acc_r    <= acc_nxt;
      box_r    <= box_nxt;
      slot_r   <= slot_nxt;
      ovalid_r <= ovalid_nxt;
    end
    right_r <= right_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tvalid = ovalid_r;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for blob_centroid_and_bounding_box. Pixel words are
// streamed in under random sender and receiver gaps; a cycle-free model
// of the counters, accumulators, box and slot pointer predicts each frame
// result, and every result item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import bcb_pkg::*;

  localparam int WIDTH_LIMIT   = 512;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int HIST_LIMIT    = 60;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    box_t               box;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   count;
  } frame_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [31:0]           in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [87:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  blob_centroid_and_bounding_box u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state, starting from the reset values
  logic [WIDTH_W-1:0]  p_width  = RST_WIDTH;
  logic [HEIGHT_W-1:0] p_height = RST_HEIGHT;
  box_t                p_start  = {RST_XMIN, RST_XMAX, RST_YMIN, RST_YMAX};
  logic [SLOT_W-1:0]   p_hist   = RST_HIST;
  logic [BYTE_W-1:0]   p_thresh = RST_THRESH;
  logic [COL_W-1:0]    p_col    = '0;
  logic [ROW_W-1:0]    p_row    = '0;
  logic [SUM_W-1:0]    p_sum_x  = '0;
  logic [SUM_W-1:0]    p_sum_y  = '0;
  logic [CNT_W-1:0]    p_count  = '0;
  box_t                p_box    = {RST_XMIN, RST_XMAX, RST_YMIN, RST_YMAX};
  logic [SLOT_W-1:0]   p_slot   = '0;

  logic [31:0]   word_q[$];
  frame_result_t frame_results_q[$];
  frame_result_t got_res;
  frame_result_t want_res;

  int unsigned send_gap_pct = 29;
  int unsigned recv_gap_pct = 81;
  logic        recv_hold    = 1'b0;
  int          mismatches   = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic take_pixel(logic [7:0] red, logic [7:0] green,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    if (red > p_thresh) begin
      p_sum_x = p_sum_x + x;
      p_sum_y = p_sum_y + y;
      p_count = p_count + 1'b1;
    end
    if (green > p_thresh) begin
      if (x < p_box.xmin) p_box.xmin = x;
      if (x > p_box.xmax) p_box.xmax = x;
      if (y < p_box.ymin) p_box.ymin = y;
      if (y > p_box.ymax) p_box.ymax = y;
    end
  endtask

  task automatic track_word(logic [31:0] w);
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      hl;
    logic [SUM_W-1:0] qx;
    logic [SUM_W-1:0] qy;
    bit               row_end;
    bit               frame_end;
    frame_result_t    res;
    wd = clamp_size(p_width, WIDTH_LIMIT);
    ht = clamp_size(p_height, HEIGHT_LIMIT);
    row_end = int'(p_col) + 1 >= wd;
    frame_end = row_end && (int'(p_row) + 1 >= ht);
    if (p_col == 0 && p_row == 0) p_box = p_start;
    take_pixel(w[7:0], w[15:8], {p_col, 1'b0}, p_row);
    take_pixel(w[23:16], w[31:24], {p_col, 1'b1}, p_row);
    if (!row_end) begin
      p_col = p_col + 1'b1;
    end else begin
      p_col = '0;
      if (!frame_end) begin
        p_row = p_row + 1'b1;
      end else begin
        p_row = '0;
        res = '0;
        res.found = p_count != 0;
        res.box = p_box;
        res.count = p_count;
        if (res.found) begin
          hl = clamp_size(p_hist, HIST_LIMIT);
          qx = p_sum_x / p_count;
          qy = p_sum_y / p_count;
          res.cx = qx[COORD_W-1:0];
          res.cy = qy[COORD_W-1:0];
          res.slot = p_slot;
          p_slot = (int'(p_slot) + 1 >= hl) ? '0 : p_slot + 1'b1;
        end
        frame_results_q.push_back(res);
        p_sum_x = '0;
        p_sum_y = '0;
        p_count = '0;
      end
    end
  endtask

  function automatic logic [7:0] mask_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hff;
      2: return p_thresh;
      3: return p_thresh + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    return {mask_byte(), mask_byte(), mask_byte(), mask_byte()};
  endfunction

  function automatic int unsigned corner_value();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 1023 : 0;
    return $urandom_range(1023);
  endfunction

  task automatic set_reg(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    case (idx)
      REG_WIDTH:  p_width = WIDTH_W'(val);
      REG_HEIGHT: p_height = HEIGHT_W'(val);
      REG_XMIN:   p_start.xmin = COORD_W'(val);
      REG_XMAX:   p_start.xmax = COORD_W'(val);
      REG_YMIN:   p_start.ymin = COORD_W'(val);
      REG_YMAX:   p_start.ymax = COORD_W'(val);
      REG_HIST:   p_hist = SLOT_W'(val);
      REG_THRESH: p_thresh = BYTE_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned x0, int unsigned x1,
                           int unsigned y0, int unsigned y1, int unsigned hist,
                           int unsigned thr);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    set_reg(REG_XMIN, x0);
    set_reg(REG_XMAX, x1);
    set_reg(REG_YMIN, y0);
    set_reg(REG_YMAX, y1);
    set_reg(REG_HIST, hist);
    set_reg(REG_THRESH, thr);
  endtask

  // wait until every item is in and every frame result is out, then let
  // the block run dry
  task automatic settle();
    @(negedge clk);
    while (word_q.size() != 0 || in_tvalid || frame_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // pixel word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_word(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_tdata  <= word_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // frame result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res.found    = out_tuser;
        got_res.cx       = out_tdata[9:0];
        got_res.cy       = out_tdata[19:10];
        got_res.box.xmin = out_tdata[29:20];
        got_res.box.xmax = out_tdata[39:30];
        got_res.box.ymin = out_tdata[49:40];
        got_res.box.ymax = out_tdata[59:50];
        got_res.slot     = out_tdata[65:60];
        got_res.count    = out_tdata[86:66];
        if (frame_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: found=%0d c=(%0d,%0d) count=%0d",
                     got_res.found, got_res.cx, got_res.cy, got_res.count);
        end else begin
          want_res = frame_results_q.pop_front();
          // slot only means something when a blob was found
          if (!want_res.found) got_res.slot = want_res.slot;
          if (got_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: found=%0d c=(%0d,%0d) x=[%0d,%0d] y=[%0d,%0d] slot=%0d count=%0d",
                       want_res.found, want_res.cx, want_res.cy, want_res.box.xmin,
                       want_res.box.xmax, want_res.box.ymin, want_res.box.ymax,
                       want_res.slot, want_res.count);
              $display("mismatch actual:   found=%0d c=(%0d,%0d) x=[%0d,%0d] y=[%0d,%0d] slot=%0d count=%0d",
                       got_res.found, got_res.cx, got_res.cy, got_res.box.xmin,
                       got_res.box.xmax, got_res.box.ymin, got_res.box.ymax,
                       got_res.slot, got_res.count);
            end
          end
        end
      end
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two rows at the reset settings, the frame is closed by the resize below
    repeat (40 * 2) word_q.push_back(rand_word());
    settle();

    // single-word frames, threshold edges and each pixel alone
    set_frame(1, 1, 1023, 0, 1023, 0, 60, 128);
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'hffff_ffff);
    word_q.push_back(32'h8080_8080);
    word_q.push_back(32'h8181_8181);
    word_q.push_back(32'h0000_00ff);
    word_q.push_back(32'h00ff_0000);
    word_q.push_back(32'h0000_ff00);
    word_q.push_back(32'hff00_0000);
    settle();
    set_reg(REG_THRESH, 0);
    word_q.push_back(32'h0000_0000);
    word_q.push_back(32'h0101_0101);
    settle();
    set_reg(REG_THRESH, 255);
    word_q.push_back(32'hffff_ffff);
    settle();

    // zero size registers act as one
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 0);
    set_reg(REG_THRESH, 128);
    word_q.push_back(32'h00ff_00ff);
    word_q.push_back(32'hffff_ffff);
    settle();

    // slot pointer already past a shorter history
    set_reg(REG_HIST, 2);
    repeat (3) word_q.push_back(32'hffff_ffff);
    settle();

    // size and box changes in mid frame
    set_frame(4, 4, 1023, 0, 1023, 0, 5, 100);
    repeat (6) word_q.push_back(rand_word());
    settle();
    set_reg(REG_WIDTH, 2);
    set_reg(REG_XMIN, 5);
    word_q.push_back(rand_word());
    settle();
    set_reg(REG_HEIGHT, 1);
    repeat (4) word_q.push_back(rand_word());
    settle();

    // oversized size registers clamp, then shrinking them ends the frame
    set_frame(1023, 2047, 1023, 0, 1023, 0, 63, 200);
    repeat (40) word_q.push_back(rand_word());
    settle();
    set_reg(REG_WIDTH, 1);
    word_q.push_back(rand_word());
    settle();
    set_reg(REG_HEIGHT, 1);
    word_q.push_back(rand_word());
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        send_gap_pct = 29;
        recv_gap_pct = 81;
      end else if (ph == 4) begin
        send_gap_pct = 81;
        recv_gap_pct = 29;
      end else if (ph == 8) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      if (ph == 5) begin
        // found on every word, full history wrap, receiver stalled long
        set_frame(1, 1, 1023, 0, 1023, 0, 63, 0);
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(negedge clk);
            recv_hold = 1'b0;
          end
        join_none
        repeat (70) word_q.push_back(rand_word() | 32'h0000_0001);
      end else begin
        set_frame($urandom_range(4), $urandom_range(4), corner_value(), corner_value(),
                  corner_value(), corner_value(),
                  ($urandom_range(3) == 0) ? 0 : (($urandom_range(3) == 0) ? 63 :
                                                   $urandom_range(1, 60)),
                  ($urandom_range(4) == 0) ? 0 : (($urandom_range(4) == 0) ? 255 :
                                                   $urandom_range(255)));
        repeat (20) word_q.push_back(rand_word());
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("** blob_centroid_and_bounding_box: PASSED **");
    end else begin
      $display("** blob_centroid_and_bounding_box: FAILED **");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("** blob_centroid_and_bounding_box: FAILED **");
    $finish;
  end

endmodule
